// ===== rtl/pcsp_pkg.sv =====
// ----------------------------------------------------------------------------
// pcsp_pkg: shared types, constants and functions
// Phase and chunk code enums, result record, PNG signature bytes and the
// byte-wide CRC-32 update used by the chunk stream parser.
// ----------------------------------------------------------------------------
package pcsp_pkg;

  // Parser phases
  typedef enum logic [2:0] {
    PH_SIG  = 3'd0,
    PH_LEN  = 3'd1,
    PH_TYPE = 3'd2,
    PH_DATA = 3'd3,
    PH_CRC  = 3'd4,
    PH_DEAD = 3'd5
  } phase_e;

  // Chunk codes as reported on the result stream
  typedef enum logic [1:0] {
    CODE_TEXT  = 2'd0,
    CODE_ZTXT  = 2'd1,
    CODE_TIME  = 2'd2,
    CODE_OTHER = 2'd3
  } code_e;

  // Result kinds
  localparam logic [2:0] KIND_KEY     = 3'd0;
  localparam logic [2:0] KIND_VALUE   = 3'd1;
  localparam logic [2:0] KIND_ZBYTE   = 3'd2;
  localparam logic [2:0] KIND_VERDICT = 3'd3;
  localparam logic [2:0] KIND_BADSIG  = 3'd4;

  // Chunk type words, big-endian ASCII
  localparam logic [31:0] TYPE_TEXT = 32'h7445_5874;
  localparam logic [31:0] TYPE_ZTXT = 32'h7a54_5874;
  localparam logic [31:0] TYPE_TIME = 32'h7449_4d45;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  localparam int unsigned TIME_BYTES = 7;

  // File signature
  localparam logic [7:0] SIG_BYTES [8] = '{
    8'h89, 8'h50, 8'h4e, 8'h47, 8'h0d, 8'h0a, 8'h1a, 8'h0a
  };

  // One result item
  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  out_byte;
    logic [1:0]  chunk_code;
    logic        crc_ok;
    logic [15:0] year;
    logic [7:0]  month;
    logic [7:0]  day;
    logic [7:0]  hour;
    logic [7:0]  minute;
    logic [7:0]  second;
  } result_t;

  // CRC register control from the parser
  typedef struct packed {
    logic init;
    logic upd;
  } crc_ctl_t;

  // Parser status seen by the top level
  typedef struct packed {
    phase_e phase;
  } ctrl_stat_t;

  // Map a type word to its chunk code
  function automatic code_e type_code(logic [31:0] t);
    code_e c;
    if (t == TYPE_TEXT)      c = CODE_TEXT;
    else if (t == TYPE_ZTXT) c = CODE_ZTXT;
    else if (t == TYPE_TIME) c = CODE_TIME;
    else                     c = CODE_OTHER;
    return c;
  endfunction

  // Reflected CRC-32 over one byte, eight XOR stages
  function automatic logic [31:0] crc32_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/png_chunk_stream_parser_core.sv =====
// ----------------------------------------------------------------------------
// png_chunk_stream_parser_core: PNG chunk stream parser with CRC-32 check
// Checks the file signature, parses chunks, streams tEXt/zTXt text bytes
// and reports a CRC verdict (with timestamp for tIME) per chunk of interest.
//
//   channel   dir  tdata                                   tuser
//   s_axis    in   [7:0] data_byte                         -
//   m_axis    out  out_byte, chunk_code, crc_ok, year,     [2:0] kind
//                  month, day, hour, minute, second
//
// One byte is taken per clock while the result buffer is not full; each
// byte yields zero or one result, registered in the buffer before m_axis.
// s_axis_tready drops only while both result buffer slots are occupied.
// Reset clears the parser to the signature phase and empties the buffer.
// After a bad signature all bytes are taken and dropped until reset.
// ----------------------------------------------------------------------------
module png_chunk_stream_parser_core
  import pcsp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] out_byte, [9:8] chunk_code, [10] crc_ok, [26:11] year,
  // [34:27] month, [42:35] day, [50:43] hour, [58:51] minute,
  // [66:59] second, [71:67] zero
  output logic [71:0] m_axis_tdata,
  output logic [2:0]  m_axis_tuser    // [2:0] kind
);

  logic       acc;
  logic       buf_full;
  logic       res_valid;
  result_t    res;
  result_t    head;
  crc_ctl_t   crc_ctl;
  ctrl_stat_t stat;
  logic [31:0] crc;

  assign s_axis_tready = ~buf_full;
  assign acc           = s_axis_tvalid & s_axis_tready;

  pcsp_crc u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (crc_ctl),
    .byte_i (s_axis_tdata),
    .crc_o  (crc)
  );

  pcsp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .byte_i      (s_axis_tdata),
    .crc_i       (crc),
    .crc_ctl_o   (crc_ctl),
    .res_valid_o (res_valid),
    .res_o       (res),
    .stat_o      (stat)
  );

  pcsp_obuf u_obuf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (res_valid),
    .wr_data_i (res),
    .full_o    (buf_full),
    .valid_o   (m_axis_tvalid),
    .rd_i      (m_axis_tready),
    .rd_data_o (head)
  );

  // output packing
  assign m_axis_tuser = head.kind;
  assign m_axis_tdata = {5'd0, head.second, head.minute, head.hour, head.day,
                         head.month, head.year, head.crc_ok, head.chunk_code,
                         head.out_byte};

`ifndef SYNTH
  // nothing is produced once the signature has failed
  a_dead_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat.phase == PH_DEAD) |-> !res_valid)
    else $error("result produced after bad signature");

  // a bad signature report moves the parser to the dead phase
  a_badsig_dead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res.kind == KIND_BADSIG) |=> (stat.phase == PH_DEAD))
    else $error("bad signature without dead phase");

  // input stall only when results are pending
  a_stall_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with empty result buffer");

  // the CRC register is only touched on accepted bytes
  a_crc_on_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (crc_ctl.init || crc_ctl.upd) |-> acc)
    else $error("CRC changed without a transfer");
`endif

endmodule

// ===== rtl/pcsp_crc.sv =====
// ----------------------------------------------------------------------------
// pcsp_crc: running CRC-32 register
// Preset to all ones on init, folds in one byte per update.
// ----------------------------------------------------------------------------
module pcsp_crc
  import pcsp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  crc_ctl_t    ctl_i,
  input  logic [7:0]  byte_i,
  output logic [31:0] crc_o
);

  logic [31:0] crc_q;
  logic [31:0] crc_d;

  // next CRC value
  always_comb begin
    priority if (ctl_i.init) begin
      crc_d = CRC_INIT;
    end else if (ctl_i.upd) begin
      crc_d = crc32_byte(crc_q, byte_i);
    end else begin
      crc_d = crc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= CRC_INIT;
    end else begin
      crc_q <= crc_d;
    end
  end

  assign crc_o = crc_q;

endmodule

// ===== rtl/pcsp_ctrl.sv =====
// ----------------------------------------------------------------------------
// pcsp_ctrl: chunk parser state machine
// Walks signature, length, type, data and CRC fields one byte per transfer,
// and builds at most one result per accepted byte.
// ----------------------------------------------------------------------------
module pcsp_ctrl
  import pcsp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        acc_i,
  input  logic [7:0]  byte_i,
  input  logic [31:0] crc_i,
  output crc_ctl_t    crc_ctl_o,
  output logic        res_valid_o,
  output result_t     res_o,
  output ctrl_stat_t  stat_o
);

  phase_e      phase_q, phase_d;
  logic [2:0]  sig_idx_q, sig_idx_d;
  logic [30:0] cnt_q, cnt_d;
  logic [30:0] len_q, len_d;
  logic [23:0] type_q, type_d;
  code_e       code_q, code_d;
  logic [23:0] rcv_q, rcv_d;
  logic        sep_q, sep_d;
  logic        meth_q, meth_d;
  logic [7:0]  time_q [TIME_BYTES];

  logic [30:0] cnt_inc;
  logic        quad_last;
  logic        data_last;
  logic        sig_bad;
  logic [31:0] type_full;
  logic        time_clr;
  logic        time_wr;

  assign cnt_inc   = cnt_q + 31'd1;
  assign quad_last = (cnt_q[1:0] == 2'd3);
  assign data_last = (cnt_inc >= len_q);
  assign sig_bad   = (byte_i != SIG_BYTES[sig_idx_q]);
  assign type_full = {type_q, byte_i};

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (acc_i) begin
      unique case (phase_q)
        PH_SIG: begin
          if (sig_bad) phase_d = PH_DEAD;
          else if (sig_idx_q == 3'd7) phase_d = PH_LEN;
        end
        PH_LEN: begin
          if (quad_last) phase_d = PH_TYPE;
        end
        PH_TYPE: begin
          if (quad_last) phase_d = (len_q == 31'd0) ? PH_CRC : PH_DATA;
        end
        PH_DATA: begin
          if (data_last) phase_d = PH_CRC;
        end
        PH_CRC: begin
          if (quad_last) phase_d = PH_LEN;
        end
        PH_DEAD: phase_d = PH_DEAD;
        default: phase_d = PH_DEAD;
      endcase
    end
  end

  // datapath updates and result
  always_comb begin
    sig_idx_d   = sig_idx_q;
    cnt_d       = cnt_q;
    len_d       = len_q;
    type_d      = type_q;
    code_d      = code_q;
    rcv_d       = rcv_q;
    sep_d       = sep_q;
    meth_d      = meth_q;
    time_clr    = 1'b0;
    time_wr     = 1'b0;
    crc_ctl_o   = '0;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (acc_i) begin
      unique case (phase_q)
        PH_SIG: begin
          if (sig_bad) begin
            res_valid_o = 1'b1;
            res_o.kind   = KIND_BADSIG;
          end else if (sig_idx_q == 3'd7) begin
            sig_idx_d = 3'd0;
            cnt_d     = '0;
          end else begin
            sig_idx_d = sig_idx_q + 3'd1;
          end
        end
        PH_LEN: begin
          len_d = {len_q[22:0], byte_i};
          if (quad_last) begin
            cnt_d          = '0;
            crc_ctl_o.init = 1'b1;
          end else begin
            cnt_d = cnt_inc;
          end
        end
        PH_TYPE: begin
          type_d        = type_full[23:0];
          crc_ctl_o.upd = 1'b1;
          if (quad_last) begin
            cnt_d    = '0;
            sep_d    = 1'b0;
            meth_d   = 1'b0;
            code_d   = type_code(type_full);
            time_clr = (type_code(type_full) == CODE_TIME);
          end else begin
            cnt_d = cnt_inc;
          end
        end
        PH_DATA: begin
          crc_ctl_o.upd = 1'b1;
          cnt_d         = data_last ? '0 : cnt_inc;
          if (code_q == CODE_TEXT || code_q == CODE_ZTXT) begin
            if (!sep_q) begin
              if (byte_i == 8'd0) begin
                sep_d = 1'b1;
              end else begin
                res_valid_o      = 1'b1;
                res_o.kind       = KIND_KEY;
                res_o.out_byte   = byte_i;
                res_o.chunk_code = code_q;
              end
            end else if (code_q == CODE_ZTXT && !meth_q) begin
              meth_d = 1'b1;
            end else begin
              res_valid_o      = 1'b1;
              res_o.kind       = (code_q == CODE_TEXT) ? KIND_VALUE : KIND_ZBYTE;
              res_o.out_byte   = byte_i;
              res_o.chunk_code = code_q;
            end
          end else if (code_q == CODE_TIME) begin
            time_wr = (cnt_q < 31'(TIME_BYTES));
          end
        end
        PH_CRC: begin
          rcv_d = {rcv_q[15:0], byte_i};
          if (quad_last) begin
            cnt_d = '0;
            if (code_q != CODE_OTHER) begin
              res_valid_o      = 1'b1;
              res_o.kind       = KIND_VERDICT;
              res_o.chunk_code = code_q;
              res_o.crc_ok     = ({rcv_q, byte_i} == ~crc_i);
              if (code_q == CODE_TIME) begin
                res_o.year   = {time_q[0], time_q[1]};
                res_o.month  = time_q[2];
                res_o.day    = time_q[3];
                res_o.hour   = time_q[4];
                res_o.minute = time_q[5];
                res_o.second = time_q[6];
              end
            end
          end else begin
            cnt_d = cnt_inc;
          end
        end
        PH_DEAD: begin
          res_valid_o = 1'b0;
        end
        default: begin
          res_valid_o = 1'b0;
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_SIG;
      sig_idx_q <= '0;
      cnt_q     <= '0;
      code_q    <= CODE_OTHER;
      sep_q     <= 1'b0;
      meth_q    <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      sig_idx_q <= sig_idx_d;
      cnt_q     <= cnt_d;
      code_q    <= code_d;
      sep_q     <= sep_d;
      meth_q    <= meth_d;
    end
  end

  // field payload registers
  always_ff @(posedge clk_i) begin
    len_q  <= len_d;
    type_q <= type_d;
    rcv_q  <= rcv_d;
  end

  // tIME buffer: cleared when the type is seen, then filled by position
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < TIME_BYTES; i++) begin
      if (time_clr) begin
        time_q[i] <= 8'd0;
      end else if (time_wr && (cnt_q[2:0] == 3'(i))) begin
        time_q[i] <= byte_i;
      end
    end
  end

  assign stat_o.phase = phase_q;

endmodule

// ===== rtl/pcsp_obuf.sv =====
// ----------------------------------------------------------------------------
// pcsp_obuf: two-entry result buffer
// Holds finished results so the parser keeps taking bytes while the
// downstream side stalls, until both entries are occupied.
// ----------------------------------------------------------------------------
module pcsp_obuf
  import pcsp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    wr_i,
  input  result_t wr_data_i,
  output logic    full_o,
  output logic    valid_o,
  input  logic    rd_i,
  output result_t rd_data_o
);

  result_t    mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_rd;

  assign do_rd = rd_i && (cnt_q != 2'd0);

  // pointers and fill count
  always_comb begin
    wr_ptr_d = wr_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_rd ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, wr_i} - {1'b0, do_rd};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  assign full_o    = (cnt_q == 2'd2);
  assign valid_o   = (cnt_q != 2'd0);
  assign rd_data_o = mem_q[rd_ptr_q];

endmodule

// ===== tb/sv/tb_png_chunk_stream_parser_core.sv =====
// ----------------------------------------------------------------------------
// tb_png_chunk_stream_parser_core: self-checking bench for the chunk parser
// Sends a valid file signature, a short table of directed bytes and then a
// long run of random chunks (tEXt, zTXt, tIME, foreign and near-miss types,
// empty and oversized lengths, good and corrupted CRCs) with random idle on
// both streams. A byte-level parser model predicts the random transfers and
// the table the directed ones, compared field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_png_chunk_stream_parser_core;
  import pcsp_pkg::*;

  localparam int N_BYTES     = 1950;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN       = 8;
  localparam int PRINT_CAP   = 30;

  // How a directed row gets its expectation
  typedef enum logic [1:0] {
    ROW_MODEL,   // whatever the parser model says
    ROW_QUIET,   // no output transfer
    ROW_GIVEN    // the result typed into the table
  } check_e;

  typedef struct {
    logic [7:0] b;
    check_e     how;
    result_t    want;
  } dir_row_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;

  png_chunk_stream_parser_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Signature, then a 4-byte tEXt chunk "K" NUL FF NUL with a zero CRC
  dir_row_t dir_rows [24] = '{
    '{8'h89, ROW_QUIET, '0}, '{8'h50, ROW_QUIET, '0},
    '{8'h4e, ROW_QUIET, '0}, '{8'h47, ROW_QUIET, '0},
    '{8'h0d, ROW_QUIET, '0}, '{8'h0a, ROW_QUIET, '0},
    '{8'h1a, ROW_QUIET, '0}, '{8'h0a, ROW_QUIET, '0},
    '{8'h00, ROW_QUIET, '0}, '{8'h00, ROW_QUIET, '0},
    '{8'h00, ROW_QUIET, '0}, '{8'h04, ROW_QUIET, '0},
    '{8'h74, ROW_QUIET, '0}, '{8'h45, ROW_QUIET, '0},
    '{8'h58, ROW_QUIET, '0}, '{8'h74, ROW_QUIET, '0},
    '{8'h4b, ROW_GIVEN, {KIND_KEY, 8'h4b, CODE_TEXT, 1'b0, 56'd0}},
    '{8'h00, ROW_QUIET, '0},
    '{8'hff, ROW_GIVEN, {KIND_VALUE, 8'hff, CODE_TEXT, 1'b0, 56'd0}},
    '{8'h00, ROW_GIVEN, {KIND_VALUE, 8'h00, CODE_TEXT, 1'b0, 56'd0}},
    '{8'h00, ROW_QUIET, '0}, '{8'h00, ROW_QUIET, '0},
    '{8'h00, ROW_QUIET, '0},
    '{8'h00, ROW_GIVEN, {KIND_VERDICT, 8'h00, CODE_TEXT, 1'b0, 56'd0}}
  };

  // Parser model state
  phase_e      stage       = PH_SIG;
  logic [2:0]  sig_pos     = '0;
  logic [30:0] cnt         = '0;
  logic [30:0] len         = '0;
  logic [31:0] ctype       = '0;
  logic [31:0] crc         = CRC_INIT;
  logic [31:0] got_crc     = '0;
  logic        nul_seen    = 1'b0;
  logic        method_gone = 1'b0;
  logic [7:0]  stamp [7]   = '{default: 8'h00};

  result_t     pending_results [$];
  logic [7:0]  chunk_body [$];

  int idle_mode = 1;   // 0 none, 1 light, 2 heavy
  int n_bytes   = 0;
  int n_checked = 0;
  int n_bad     = 0;
  int n_mismatch = 0;
  int n_chunks [4] = '{default: 0};
  int sink_hold = 0;

  // Reflected CRC-32, one input bit at a time
  function automatic logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
    logic [31:0] r;
    r = c;
    for (int i = 0; i < 8; i++) begin
      if (r[0] ^ b[i]) r = (r >> 1) ^ CRC_POLY;
      else r = r >> 1;
    end
    return r;
  endfunction

  function automatic code_e classify_type(logic [31:0] t);
    code_e c;
    case (t)
      TYPE_TEXT: c = CODE_TEXT;
      TYPE_ZTXT: c = CODE_ZTXT;
      TYPE_TIME: c = CODE_TIME;
      default:   c = CODE_OTHER;
    endcase
    return c;
  endfunction

  // Idle length: none in mode 0, otherwise a mix of none, short and long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99, 0);
    if (idle_mode == 0) return 0;
    if (idle_mode == 1) begin
      if (r < 70) return 0;
      if (r < 97) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
    end
    if (r < 35) return 0;
    if (r < 85) return $urandom_range(4, 1);
    return $urandom_range(40, 8);
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got_v,
                                 input longint unsigned want_v);
    n_mismatch++;
    if (n_mismatch <= PRINT_CAP)
      $display("[%0t] %s: got 0x%0h, want 0x%0h", $time, what, got_v, want_v);
  endtask

  // Advance the model by one file byte; has is set when a result is due
  task automatic parse_byte(input logic [7:0] b, output bit has, output result_t r);
    code_e c;
    has = 1'b0;
    r   = '0;
    case (stage)
      PH_SIG: begin
        if (b != SIG_BYTES[sig_pos]) begin
          stage  = PH_DEAD;
          r.kind = KIND_BADSIG;
          has    = 1'b1;
        end else if (sig_pos == 3'd7) begin
          sig_pos = '0;
          stage   = PH_LEN;
          cnt     = '0;
          len     = '0;
        end else begin
          sig_pos = sig_pos + 3'd1;
        end
      end
      PH_LEN: begin
        // bit 31 of the length falls off the top
        len = {len[22:0], b};
        cnt = cnt + 31'd1;
        if (cnt >= 31'd4) begin
          cnt   = '0;
          ctype = '0;
          crc   = CRC_INIT;
          stage = PH_TYPE;
        end
      end
      PH_TYPE: begin
        ctype = {ctype[23:0], b};
        crc   = crc_step(crc, b);
        cnt   = cnt + 31'd1;
        if (cnt >= 31'd4) begin
          cnt         = '0;
          nul_seen    = 1'b0;
          method_gone = 1'b0;
          got_crc     = '0;
          if (classify_type(ctype) == CODE_TIME) begin
            foreach (stamp[i]) stamp[i] = 8'h00;
          end
          stage = (len == '0) ? PH_CRC : PH_DATA;
        end
      end
      PH_DATA: begin
        c   = classify_type(ctype);
        crc = crc_step(crc, b);
        if (c == CODE_TEXT || c == CODE_ZTXT) begin
          if (!nul_seen) begin
            if (b == 8'h00) begin
              nul_seen = 1'b1;
            end else begin
              r.kind = KIND_KEY;
              r.out_byte = b;
              r.chunk_code = c;
              has = 1'b1;
            end
          end else if (c == CODE_ZTXT && !method_gone) begin
            // compression method byte is dropped
            method_gone = 1'b1;
          end else begin
            r.kind = (c == CODE_TEXT) ? KIND_VALUE : KIND_ZBYTE;
            r.out_byte = b;
            r.chunk_code = c;
            has = 1'b1;
          end
        end else if (c == CODE_TIME) begin
          if (cnt < 31'd7) stamp[cnt[2:0]] = b;
        end
        cnt = cnt + 31'd1;
        if (cnt >= len) begin
          cnt   = '0;
          stage = PH_CRC;
        end
      end
      PH_CRC: begin
        got_crc = {got_crc[23:0], b};
        cnt     = cnt + 31'd1;
        if (cnt >= 31'd4) begin
          c = classify_type(ctype);
          if (c != CODE_OTHER) begin
            r.kind = KIND_VERDICT;
            r.chunk_code = c;
            r.crc_ok = (got_crc == ~crc);
            if (c == CODE_TIME) begin
              r.year   = {stamp[0], stamp[1]};
              r.month  = stamp[2];
              r.day    = stamp[3];
              r.hour   = stamp[4];
              r.minute = stamp[5];
              r.second = stamp[6];
            end
            has = 1'b1;
          end
          cnt   = '0;
          len   = '0;
          stage = PH_LEN;
        end
      end
      default: ;
    endcase
  endtask

  // One input transfer, with an optional idle gap in front
  task automatic send_byte(input logic [7:0] b, input check_e how = ROW_MODEL,
                           input result_t given = '0);
    int gap;
    bit has;
    result_t r;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    n_bytes++;
    parse_byte(b, has, r);
    case (how)
      ROW_MODEL: if (has) pending_results.push_back(r);
      ROW_GIVEN: pending_results.push_back(given);
      default: ;
    endcase
  endtask

  // Length, type, chunk_body and CRC, all big-endian
  task automatic send_chunk(input logic [31:0] tword, input logic [31:0] lfield,
                            input bit corrupt);
    logic [31:0] sum;
    sum = CRC_INIT;
    for (int i = 3; i >= 0; i--) send_byte(lfield[8*i +: 8]);
    for (int i = 3; i >= 0; i--) begin
      send_byte(tword[8*i +: 8]);
      sum = crc_step(sum, tword[8*i +: 8]);
    end
    foreach (chunk_body[i]) begin
      send_byte(chunk_body[i]);
      sum = crc_step(sum, chunk_body[i]);
    end
    sum = ~sum;
    if (corrupt) sum = sum ^ (32'd1 << $urandom_range(31, 0));
    for (int i = 3; i >= 0; i--) send_byte(sum[8*i +: 8]);
  endtask

  // Output backpressure
  always @(posedge clk_i) begin
    if (sink_hold != 0) sink_hold = sink_hold - 1;
    else sink_hold = pick_gap();
    m_axis_tready <= (sink_hold == 0);
  end

  // Compare each output transfer with the oldest prediction
  always @(posedge clk_i) begin : result_check
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.kind       = m_axis_tuser;
      got.out_byte   = m_axis_tdata[7:0];
      got.chunk_code = m_axis_tdata[9:8];
      got.crc_ok     = m_axis_tdata[10];
      got.year       = m_axis_tdata[26:11];
      got.month      = m_axis_tdata[34:27];
      got.day        = m_axis_tdata[42:35];
      got.hour       = m_axis_tdata[50:43];
      got.minute     = m_axis_tdata[58:51];
      got.second     = m_axis_tdata[66:59];
      if (pending_results.size() == 0) begin
        report_mismatch("result with none pending, kind", got.kind, 0);
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (got.kind != want.kind) report_mismatch("kind", got.kind, want.kind);
        if (got.out_byte != want.out_byte)
          report_mismatch("out_byte", got.out_byte, want.out_byte);
        if (got.chunk_code != want.chunk_code)
          report_mismatch("chunk_code", got.chunk_code, want.chunk_code);
        if (got.crc_ok != want.crc_ok) report_mismatch("crc_ok", got.crc_ok, want.crc_ok);
        if (got.year != want.year) report_mismatch("year", got.year, want.year);
        if (got.month != want.month) report_mismatch("month", got.month, want.month);
        if (got.day != want.day) report_mismatch("day", got.day, want.day);
        if (got.hour != want.hour) report_mismatch("hour", got.hour, want.hour);
        if (got.minute != want.minute) report_mismatch("minute", got.minute, want.minute);
        if (got.second != want.second) report_mismatch("second", got.second, want.second);
      end
      if (m_axis_tdata[71:67] != '0) report_mismatch("tdata pad", m_axis_tdata[71:67], 0);
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("Timeout after %0d cycles, %0d results still pending",
             CYCLE_LIMIT, pending_results.size());
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    int sel;
    int blen;
    logic [31:0] tword;
    logic [31:0] lfield;
    bit corrupt;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    foreach (dir_rows[i]) send_byte(dir_rows[i].b, dir_rows[i].how, dir_rows[i].want);

    // Random chunks with random content
    while (n_bytes < N_BYTES) begin
      if ($urandom_range(9, 0) == 0) idle_mode = $urandom_range(2, 0);
      sel  = $urandom_range(99, 0);
      blen = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 0);
      if (sel < 30) begin
        tword = TYPE_TEXT;
      end else if (sel < 55) begin
        tword = TYPE_ZTXT;
      end else if (sel < 75) begin
        tword = TYPE_TIME;
        if ($urandom_range(9, 0) < 6) blen = 7;
      end else if (sel < 88) begin
        tword = $urandom;
      end else begin
        // one bit away from a type of interest
        case ($urandom_range(2, 0))
          0:       tword = TYPE_TEXT;
          1:       tword = TYPE_ZTXT;
          default: tword = TYPE_TIME;
        endcase
        tword = tword ^ (32'd1 << $urandom_range(31, 0));
      end
      chunk_body.delete();
      repeat (blen) chunk_body.push_back(($urandom_range(3, 0) == 0) ? 8'h00 : 8'($urandom));
      lfield = 32'(blen);
      if ($urandom_range(9, 0) == 0) lfield[31] = 1'b1;
      corrupt = ($urandom_range(99, 0) < 15);
      n_chunks[int'(classify_type(tword))]++;
      if (corrupt) n_bad++;
      send_chunk(tword, lfield, corrupt);
    end
    s_axis_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);

    $display("Sent %0d file bytes: random chunks %0d tEXt, %0d zTXt, %0d tIME, %0d other",
             n_bytes, n_chunks[0], n_chunks[1], n_chunks[2], n_chunks[3]);
    $display("Compared %0d output transfers; %0d random chunks carried a bad CRC",
             n_checked, n_bad);
    if (n_mismatch == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
